// ----- hdl/spi_pkg.sv -----
package spi_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int RATIO_BITS  = 16;
   localparam int PT_WIDTH    = 3 * COORD_WIDTH;
   localparam int EPS_WIDTH   = 53;
   localparam int ACC_WIDTH   = 64;
   localparam int MUL_A_WIDTH = COORD_WIDTH + 1;
   localparam int MUL_B_WIDTH = 2 * COORD_WIDTH + 3;

   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_INTERIOR = 3'd1;
   localparam logic [2:0] KIND_END      = 3'd2;
   localparam logic [2:0] KIND_START    = 3'd3;
   localparam logic [2:0] KIND_BOTH     = 3'd4;

   localparam logic [1:0] REG_POINT_A = 2'd0;
   localparam logic [1:0] REG_POINT_B = 2'd1;
   localparam logic [1:0] REG_POINT_C = 2'd2;
   localparam logic [1:0] REG_EPSILON = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] seg_end_z;
      logic signed [COORD_WIDTH-1:0] seg_end_y;
      logic signed [COORD_WIDTH-1:0] seg_end_x;
      logic signed [COORD_WIDTH-1:0] seg_start_z;
      logic signed [COORD_WIDTH-1:0] seg_start_y;
      logic signed [COORD_WIDTH-1:0] seg_start_x;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cross_z;
      logic signed [COORD_WIDTH-1:0] cross_y;
      logic signed [COORD_WIDTH-1:0] cross_x;
      logic                          point_known;
      logic [2:0]                    cross_kind;
      logic                          crossed;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       mul_step;
      logic [3:0] mul_sel;
      logic       div_start;
      logic       div_step;
      logic       scale_step;
      logic [1:0] scale_axis;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic big1;
      logic big2;
      logic opposite;
   } sts_type;

endpackage

// ----- hdl/segment_plane_intersection.sv -----
// segment/plane crossing test
// configure plane points a, b, c and det_epsilon over the csr_ apb port
// (8-byte registers at 0x00, 0x08, 0x10, 0x18) while idle
// each request on req_ carries a segment; one result follows on rsp_
// an interior crossing goes through the shared multiplier (12 products),
// the radix-2 divider (RATIO_BITS steps) and three scaling steps; other
// results skip the divider and the scaling steps
// one request is in work at a time; req_stall is high while busy
// the result sits in an output register; a stalled rsp_ holds it,
// and a new request is taken once that register is free or leaving
// reset clears the registers, the held point and its known flag
module segment_plane_intersection
   import spi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [PT_WIDTH-1:0]  pa_ff, pb_ff, pc_ff;
   logic [EPS_WIDTH-1:0] eps_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff <= '0; pb_ff <= '0; pc_ff <= '0; eps_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[4:3])
            REG_POINT_A: pa_ff  <= csr_pwdata[PT_WIDTH-1:0];
            REG_POINT_B: pb_ff  <= csr_pwdata[PT_WIDTH-1:0];
            REG_POINT_C: pc_ff  <= csr_pwdata[PT_WIDTH-1:0];
            REG_EPSILON: eps_ff <= csr_pwdata[EPS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_POINT_A: csr_prdata = 64'(pa_ff);
         REG_POINT_B: csr_prdata = 64'(pb_ff);
         REG_POINT_C: csr_prdata = 64'(pc_ff);
         REG_EPSILON: csr_prdata = 64'(eps_ff);
         default:     csr_prdata = '0;
      endcase
   end

   spi_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   spi_datapath u_datapath (
      .clock, .reset,
      .point_a(pa_ff), .point_b(pb_ff), .point_c(pc_ff), .epsilon(eps_ff),
      .req(req_data), .cmd, .sts, .result(rsp_data)
   );

endmodule

// ----- hdl/spi_datapath.sv -----
module spi_datapath
   import spi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [PT_WIDTH-1:0]   point_a,
   input  logic [PT_WIDTH-1:0]   point_b,
   input  logic [PT_WIDTH-1:0]   point_c,
   input  logic [EPS_WIDTH-1:0]  epsilon,
   input  req_type               req,
   input  cmd_type               cmd,
   output sts_type               sts,
   output rsp_type               result
);

   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   req_type                      seg_ff;
   acc_type                      u_ff [3];
   acc_type                      v_ff [3];
   acc_type                      n_ff [3];
   acc_type                      d1_ff, d2_ff;
   acc_type                      prod_ff;
   logic [ACC_WIDTH-1:0]         rem_ff, den_ff;
   logic [RATIO_BITS-1:0]        q_ff;
   logic [COORD_WIDTH-1:0]       pt_ff [3];
   logic [COORD_WIDTH-1:0]       hold_ff [3];
   logic                         held_valid_ff;
   logic [2:0]                   kind_ff;

   acc_type a_c [3], s_c [3], e_c [3];
   logic signed [MUL_A_WIDTH-1:0]             op_x;
   logic signed [MUL_B_WIDTH-1:0]             op_y;
   logic signed [MUL_A_WIDTH+MUL_B_WIDTH-1:0] prod_full;
   acc_type prod_in;
   logic [ACC_WIDTH-1:0] m1, m2, den, nm1, nm2, rem_sh;
   logic                 top;
   acc_type              diff;
   logic [COORD_WIDTH:0] dmag;
   logic [COORD_WIDTH+RATIO_BITS:0] p_lo;
   logic [ACC_WIDTH-1:0] off, p_sum;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_c[k] = acc_type'(signed'(point_a[k*COORD_WIDTH +: COORD_WIDTH]));
         s_c[k] = acc_type'(signed'(seg_ff[k*COORD_WIDTH +: COORD_WIDTH]));
         e_c[k] = acc_type'(signed'(seg_ff[(k+3)*COORD_WIDTH +: COORD_WIDTH]));
      end
   end

   // one shared multiplier sequence: 6 cross terms then 6 dot terms
   always_comb begin
      op_x = '0;
      op_y = '0;
      unique case (cmd.mul_sel)
         4'd0:  begin op_x = MUL_A_WIDTH'(u_ff[1]); op_y = MUL_B_WIDTH'(v_ff[2]); end
         4'd1:  begin op_x = MUL_A_WIDTH'(u_ff[2]); op_y = MUL_B_WIDTH'(v_ff[1]); end
         4'd2:  begin op_x = MUL_A_WIDTH'(u_ff[2]); op_y = MUL_B_WIDTH'(v_ff[0]); end
         4'd3:  begin op_x = MUL_A_WIDTH'(u_ff[0]); op_y = MUL_B_WIDTH'(v_ff[2]); end
         4'd4:  begin op_x = MUL_A_WIDTH'(u_ff[0]); op_y = MUL_B_WIDTH'(v_ff[1]); end
         4'd5:  begin op_x = MUL_A_WIDTH'(u_ff[1]); op_y = MUL_B_WIDTH'(v_ff[0]); end
         4'd6:  begin op_x = MUL_A_WIDTH'(s_c[0] - a_c[0]); op_y = MUL_B_WIDTH'(n_ff[0]); end
         4'd7:  begin op_x = MUL_A_WIDTH'(s_c[1] - a_c[1]); op_y = MUL_B_WIDTH'(n_ff[1]); end
         4'd8:  begin op_x = MUL_A_WIDTH'(s_c[2] - a_c[2]); op_y = MUL_B_WIDTH'(n_ff[2]); end
         4'd9:  begin op_x = MUL_A_WIDTH'(e_c[0] - a_c[0]); op_y = MUL_B_WIDTH'(n_ff[0]); end
         4'd10: begin op_x = MUL_A_WIDTH'(e_c[1] - a_c[1]); op_y = MUL_B_WIDTH'(n_ff[1]); end
         4'd11: begin op_x = MUL_A_WIDTH'(e_c[2] - a_c[2]); op_y = MUL_B_WIDTH'(n_ff[2]); end
         default: begin op_x = '0; op_y = '0; end
      endcase
      prod_full = op_x * op_y;
      prod_in   = acc_type'(prod_full);
   end

   always_comb begin
      m1  = d1_ff[ACC_WIDTH-1] ? 64'(-d1_ff) : 64'(d1_ff);
      m2  = d2_ff[ACC_WIDTH-1] ? 64'(-d2_ff) : 64'(d2_ff);
      den = m1 + m2;
      nm1 = m1;
      nm2 = m2;
      if (den < m1) begin
         nm1 = m1 >> 1;
         nm2 = m2 >> 1;
      end
      top    = rem_ff[ACC_WIDTH-1];
      rem_sh = rem_ff << 1;
   end

   assign sts.big1     = m1 > 64'(epsilon);
   assign sts.big2     = m2 > 64'(epsilon);
   assign sts.opposite = d1_ff[ACC_WIDTH-1] ^ d2_ff[ACC_WIDTH-1];

   always_comb begin
      diff  = e_c[cmd.scale_axis] - s_c[cmd.scale_axis];
      dmag  = diff[ACC_WIDTH-1] ? (COORD_WIDTH+1)'(-diff) : (COORD_WIDTH+1)'(diff);
      p_lo  = (COORD_WIDTH+RATIO_BITS+1)'(dmag) * (COORD_WIDTH+RATIO_BITS+1)'(q_ff);
      p_sum = ACC_WIDTH'(p_lo >> RATIO_BITS);
      off   = diff[ACC_WIDTH-1] ? -p_sum : p_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         kind_ff       <= KIND_NONE;
         for (int k = 0; k < 3; k++) hold_ff[k] <= '0;
      end else begin
         if (cmd.load) begin
            seg_ff <= req;
            for (int k = 0; k < 3; k++) begin
               u_ff[k] <= acc_type'(signed'(point_b[k*COORD_WIDTH +: COORD_WIDTH])) - a_c[k];
               v_ff[k] <= acc_type'(signed'(point_c[k*COORD_WIDTH +: COORD_WIDTH])) - a_c[k];
            end
            d1_ff <= '0;
            d2_ff <= '0;
         end
         if (cmd.mul_step) prod_ff <= prod_in;
         // accumulate the product registered on the previous step
         if (cmd.mul_step || cmd.div_start) begin
            unique case (cmd.mul_sel)
               4'd1:  n_ff[0] <= prod_ff;
               4'd2:  n_ff[0] <= n_ff[0] - prod_ff;
               4'd3:  n_ff[1] <= prod_ff;
               4'd4:  n_ff[1] <= n_ff[1] - prod_ff;
               4'd5:  n_ff[2] <= prod_ff;
               4'd6:  n_ff[2] <= n_ff[2] - prod_ff;
               4'd7, 4'd8, 4'd9: d1_ff <= d1_ff + prod_ff;
               4'd10, 4'd11, 4'd12: d2_ff <= d2_ff + prod_ff;
               default: ;
            endcase
         end
         if (cmd.div_start) begin
            rem_ff <= nm1;
            den_ff <= nm1 + nm2;
            q_ff   <= '0;
         end else if (cmd.div_step) begin
            if (top || rem_sh >= den_ff) begin
               rem_ff <= rem_sh - den_ff;
               q_ff   <= {q_ff[RATIO_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               q_ff   <= {q_ff[RATIO_BITS-2:0], 1'b0};
            end
         end
         if (cmd.scale_step)
            pt_ff[cmd.scale_axis] <= COORD_WIDTH'(s_c[cmd.scale_axis] + acc_type'(off));
         if (cmd.commit) begin
            if (sts.big1 && sts.big2) begin
               if (sts.opposite) begin
                  kind_ff <= KIND_INTERIOR;
                  held_valid_ff <= 1'b1;
                  for (int k = 0; k < 3; k++) hold_ff[k] <= pt_ff[k];
               end else begin
                  kind_ff <= KIND_NONE;
               end
            end else if (sts.big1) begin
               kind_ff <= KIND_END;
               held_valid_ff <= 1'b1;
               for (int k = 0; k < 3; k++) hold_ff[k] <= seg_ff[(k+3)*COORD_WIDTH +: COORD_WIDTH];
            end else if (sts.big2) begin
               kind_ff <= KIND_START;
               held_valid_ff <= 1'b1;
               for (int k = 0; k < 3; k++) hold_ff[k] <= seg_ff[k*COORD_WIDTH +: COORD_WIDTH];
            end else begin
               kind_ff <= KIND_BOTH;
            end
         end
      end
   end

   assign result.crossed     = kind_ff != KIND_NONE;
   assign result.cross_kind  = kind_ff;
   assign result.point_known = held_valid_ff;
   assign result.cross_x     = hold_ff[0];
   assign result.cross_y     = hold_ff[1];
   assign result.cross_z     = hold_ff[2];

endmodule

// ----- hdl/spi_control.sv -----
module spi_control
   import spi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {IDLE, MUL, DIV, SCALE, DONE, HOLD} state_type;

   state_type   state_ff;
   logic [4:0]  cnt_ff;
   logic        rsp_valid_ff;

   // room for a new request while idle, once the result slot is free or leaving
   assign req_stall = (state_ff != IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load       = (state_ff == IDLE) && !req_stall && req_valid;
      cmd.mul_step   = (state_ff == MUL);
      cmd.mul_sel    = (state_ff == MUL) ? cnt_ff[3:0] : 4'd13;
      cmd.div_start  = (state_ff == MUL) && (cnt_ff == 5'd13);
      if (cmd.div_start) cmd.mul_step = 1'b0;
      cmd.div_step   = (state_ff == DIV);
      cmd.scale_step = (state_ff == SCALE);
      cmd.scale_axis = cnt_ff[1:0];
      cmd.commit     = (state_ff == DONE) && !(rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: if (cmd.load) begin
               state_ff <= MUL;
               cnt_ff   <= '0;
            end
            MUL: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd13) begin
                  cnt_ff   <= '0;
                  state_ff <= (sts.big1 && sts.big2 && sts.opposite) ? DIV : DONE;
               end
            end
            DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(RATIO_BITS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= SCALE;
               end
            end
            SCALE: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd2) state_ff <= DONE;
            end
            DONE: if (cmd.commit) begin
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_one_work: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == MUL) else $error("load did not start work");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != IDLE |-> !cmd.load) else $error("load while busy");
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff) else $error("commit lost");

endmodule
